// ===== rtl/core/wsp_pkg.sv =====
// Shared types and constants for the work slot pool with its schedule ring.
package wsp_pkg;

  localparam int WSP_SLOTS = 16;
  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_INIT,
    OP_SCHED,
    OP_KILL,
    OP_FREE,
    OP_DRAIN,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  slot;
    logic        slot_ok;
    logic [3:0]  task_type;
    logic [31:0] handler;
    logic [31:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [3:0]  rtype;
    logic [31:0] handler;
    logic [31:0] arg;
    logic        run;
    logic        last;
  } res_t;

endpackage

// ===== rtl/core/wsp_fifo.sv =====
// Small register queue of a given item type.
module wsp_fifo import wsp_pkg::*; #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                store_q [DEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/wsp_front.sv =====
// Input side: decodes an incoming item into a command and checks its slot index.
module wsp_front import wsp_pkg::*; #(
  parameter int SLOTS = WSP_SLOTS
) (
  input  logic        push_i,
  output logic        full_o,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [3:0]  task_type_i,
  input  logic [31:0] handler_i,
  input  logic [31:0] arg_i,
  output logic        cmd_push_o,
  output cmd_t        cmd_o,
  input  logic        cmd_full_i
);

  localparam logic [2:0] KIND_ALLOC = 3'd0;
  localparam logic [2:0] KIND_INIT  = 3'd1;
  localparam logic [2:0] KIND_SCHED = 3'd2;
  localparam logic [2:0] KIND_KILL  = 3'd3;
  localparam logic [2:0] KIND_FREE  = 3'd4;
  localparam logic [2:0] KIND_DRAIN = 3'd5;

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.slot      = slot_i;
    cmd_o.slot_ok   = (int'(slot_i) < SLOTS);
    cmd_o.task_type = task_type_i;
    cmd_o.handler   = handler_i;
    cmd_o.arg       = arg_i;
    unique case (kind_i)
      KIND_ALLOC: cmd_o.op = OP_ALLOC;
      KIND_INIT:  cmd_o.op = OP_INIT;
      KIND_SCHED: cmd_o.op = OP_SCHED;
      KIND_KILL:  cmd_o.op = OP_KILL;
      KIND_FREE:  cmd_o.op = OP_FREE;
      KIND_DRAIN: cmd_o.op = OP_DRAIN;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/core/wsp_back.sv =====
// Execution side: slot marks, slot memories, the schedule ring and the drain sequencer.
module wsp_back import wsp_pkg::*; #(
  parameter int SLOTS = WSP_SLOTS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_push_o,
  output res_t res_o,
  input  logic res_full_i
);

  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int ALLOC_CHUNK = 8;
  localparam int CHUNK_W     = $clog2(ALLOC_CHUNK);
  localparam int NCHUNK      = (SLOTS + ALLOC_CHUNK - 1) / ALLOC_CHUNK;
  localparam int CNT_W       = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W       = NCHUNK * ALLOC_CHUNK;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_EXHAUSTED  = 3'd1;
  localparam logic [2:0] STAT_QUEUE_FULL = 3'd2;
  localparam logic [2:0] STAT_NOT_IN_USE = 3'd3;
  localparam logic [2:0] STAT_PENDING    = 3'd4;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ALLOC   = 3'd1;
  localparam logic [2:0] S_DR_RING = 3'd2;
  localparam logic [2:0] S_DR_SLOT = 3'd3;
  localparam logic [2:0] S_DR_EMIT = 3'd4;

  logic [SLOTS-1:0]  in_use_q, pending_q, hvalid_q;
  logic [3:0]        kind_mem  [SLOTS];
  logic [63:0]       data_mem  [SLOTS];
  logic [SLOT_W-1:0] ring_mem  [SLOTS];

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  chunk_q, chunk_d;
  logic [SLOT_W-1:0] head_q, tail_q, head_next, tail_next;
  logic [SLOT_W-1:0] ring_rd_q, pop_slot_q;
  logic [3:0]        kind_rd_q;
  logic [63:0]       data_rd_q;
  logic              pend_cap_q, hv_cap_q;

  logic [SLOT_W-1:0]        idx, free_idx;
  logic                     ring_full, ring_empty;
  logic [PAD_W-1:0]         used_pad;
  logic [ALLOC_CHUNK-1:0]   chunk_bits;
  logic                     found, last_chunk;
  logic [CHUNK_W-1:0]       enc;
  logic                     do_alloc, do_init, do_sched, do_kill, do_free;
  logic                     ring_re, slot_re;

  assign idx        = SLOT_W'(cmd_i.slot);
  assign head_next  = (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + 1'b1;
  assign tail_next  = (tail_q == SLOT_W'(SLOTS - 1)) ? '0 : tail_q + 1'b1;
  assign ring_full  = (tail_next == head_q);
  assign ring_empty = (head_q == tail_q);
  assign last_chunk = (chunk_q == CNT_W'(NCHUNK - 1));

  // Slots past the end of the pool are padded as in use so the search never picks them.
  always_comb begin
    used_pad              = '1;
    used_pad[SLOTS-1:0]   = in_use_q;
    chunk_bits            = used_pad[chunk_q*ALLOC_CHUNK +: ALLOC_CHUNK];
    found                 = 1'b0;
    enc                   = '0;
    for (int i = ALLOC_CHUNK - 1; i >= 0; i--) begin
      if (!chunk_bits[i]) begin
        found = 1'b1;
        enc   = CHUNK_W'(i);
      end
    end
    free_idx = SLOT_W'({chunk_q, enc});
  end

  always_comb begin
    state_d    = state_q;
    chunk_d    = chunk_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    do_alloc   = 1'b0;
    do_init    = 1'b0;
    do_sched   = 1'b0;
    do_kill    = 1'b0;
    do_free    = 1'b0;
    ring_re    = 1'b0;
    slot_re    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_ALLOC: begin
              chunk_d = '0;
              state_d = S_ALLOC;
            end
            OP_DRAIN: begin
              state_d = S_DR_RING;
            end
            OP_INIT, OP_SCHED, OP_KILL, OP_FREE, OP_NONE: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                res_o.last = 1'b1;
                cmd_pop_o  = 1'b1;
                do_init    = (cmd_i.op == OP_INIT) && cmd_i.slot_ok;
                do_kill    = (cmd_i.op == OP_KILL) && cmd_i.slot_ok;
                do_free    = (cmd_i.op == OP_FREE) && cmd_i.slot_ok;
                if (cmd_i.op == OP_SCHED) begin
                  priority if (!cmd_i.slot_ok || !in_use_q[idx]) begin
                    res_o.status = STAT_NOT_IN_USE;
                  end else if (pending_q[idx]) begin
                    res_o.status = STAT_PENDING;
                  end else if (ring_full) begin
                    res_o.status = STAT_QUEUE_FULL;
                  end else begin
                    res_o.status = STAT_OK;
                    do_sched     = 1'b1;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_ALLOC: begin
        if (found) begin
          if (!res_full_i) begin
            res_push_o = 1'b1;
            res_o.slot = 4'(free_idx);
            res_o.last = 1'b1;
            cmd_pop_o  = 1'b1;
            do_alloc   = 1'b1;
            state_d    = S_IDLE;
          end
        end else if (last_chunk) begin
          if (!res_full_i) begin
            res_push_o   = 1'b1;
            res_o.status = STAT_EXHAUSTED;
            res_o.last   = 1'b1;
            cmd_pop_o    = 1'b1;
            state_d      = S_IDLE;
          end
        end else begin
          chunk_d = chunk_q + 1'b1;
        end
      end
      S_DR_RING: begin
        if (ring_empty) begin
          if (!res_full_i) begin
            res_push_o = 1'b1;
            res_o.last = 1'b1;
            cmd_pop_o  = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          ring_re = 1'b1;
          state_d = S_DR_SLOT;
        end
      end
      S_DR_SLOT: begin
        slot_re = 1'b1;
        state_d = S_DR_EMIT;
      end
      S_DR_EMIT: begin
        if (!res_full_i) begin
          res_push_o    = 1'b1;
          res_o.slot    = 4'(pop_slot_q);
          res_o.rtype   = kind_rd_q;
          res_o.handler = hv_cap_q ? data_rd_q[63:32] : '0;
          res_o.arg     = hv_cap_q ? data_rd_q[31:0] : '0;
          res_o.run     = pend_cap_q && hv_cap_q && (data_rd_q[63:32] != '0);
          state_d       = S_DR_RING;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      chunk_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      in_use_q   <= '0;
      pending_q  <= '0;
      hvalid_q   <= '0;
      pend_cap_q <= 1'b0;
      hv_cap_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
      if (do_alloc) begin
        in_use_q[free_idx]  <= 1'b1;
        pending_q[free_idx] <= 1'b0;
      end
      if (do_init) begin
        hvalid_q[idx]  <= 1'b1;
        pending_q[idx] <= 1'b0;
      end
      if (do_kill) begin
        pending_q[idx] <= 1'b0;
      end
      if (do_free) begin
        in_use_q[idx]  <= 1'b0;
        pending_q[idx] <= 1'b0;
      end
      if (do_sched) begin
        pending_q[idx] <= 1'b1;
        tail_q         <= tail_next;
      end
      if (ring_re) begin
        head_q <= head_next;
      end
      // The pending mark is sampled for the run flag and cleared as the entry leaves the ring.
      if (slot_re) begin
        pend_cap_q           <= pending_q[ring_rd_q];
        hv_cap_q             <= hvalid_q[ring_rd_q];
        pending_q[ring_rd_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_sched) begin
      ring_mem[tail_q] <= idx;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_alloc) begin
      kind_mem[free_idx] <= cmd_i.task_type;
    end
    if (slot_re) begin
      kind_rd_q  <= kind_mem[ring_rd_q];
      pop_slot_q <= ring_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_init) begin
      data_mem[idx] <= {cmd_i.handler, cmd_i.arg};
    end
    if (slot_re) begin
      data_rd_q <= data_mem[ring_rd_q];
    end
  end

endmodule

// ===== rtl/core/work_slot_pool_with_dedup_fifo_unit.sv =====
// Top level of the work slot pool with its ring of scheduled slots.
//
// Items enter through a queue-style port: an item is taken when push is high and full is
// low. Results leave the same way: the oldest result sits on the result ports while empty is
// low and is taken when pop is high. A decoder feeds a two-entry command queue, an executor
// works through the commands one at a time and writes results into a two-entry result queue.
// Init, schedule, kill, free and unknown kinds give one result, which is written into the
// result queue as the command leaves the command queue; with a receiver that keeps
// up they can be taken one per cycle. Alloc searches the in-use marks eight slots per cycle,
// so its result is written once a free slot is found or the last group of eight is searched.
// Drain reads the ring and then the slot memories, giving one result for each ring entry and a
// closing result with last set once the ring is empty.
// Further items are queued while a command is being executed, up to the command queue depth.
// When the receiver stops popping, the result queue fills and the executor holds its current
// step; nothing is dropped. Reset clears all marks and ring pointers at once; slot contents
// that were never written read as zero.
module work_slot_pool_with_dedup_fifo_unit import wsp_pkg::*; #(
  parameter int SLOTS = WSP_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  kind_i,
  input  logic [3:0]  slot_i,
  input  logic [3:0]  task_type_i,
  input  logic [31:0] handler_i,
  input  logic [31:0] arg_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [3:0]  out_slot_o,
  output logic [3:0]  out_type_o,
  output logic [31:0] out_handler_o,
  output logic [31:0] out_arg_o,
  output logic        run_o,
  output logic        last_o
);

  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  res_t res_in, res_head;
  logic res_push, res_full;

  wsp_front #(.SLOTS(SLOTS)) u_front (
    .push_i      (push),
    .full_o      (full),
    .kind_i      (kind_i),
    .slot_i      (slot_i),
    .task_type_i (task_type_i),
    .handler_i   (handler_i),
    .arg_i       (arg_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  wsp_fifo #(.T(cmd_t), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_head)
  );

  wsp_back #(.SLOTS(SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  wsp_fifo #(.T(res_t), .DEPTH(RES_DEPTH)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_head)
  );

  assign status_o      = res_head.status;
  assign out_slot_o    = res_head.slot;
  assign out_type_o    = res_head.rtype;
  assign out_handler_o = res_head.handler;
  assign out_arg_o     = res_head.arg;
  assign run_o         = res_head.run;
  assign last_o        = res_head.last;

endmodule

// ===== bench/slot_pool_check_pkg.sv =====
// Item record, status codes and the scoreboard class for the slot pool testbench.
package slot_pool_check_pkg;
  import wsp_pkg::*;

  typedef enum logic [2:0] {
    ST_OK,
    ST_POOL_EXHAUSTED,
    ST_RING_FULL,
    ST_NOT_IN_USE,
    ST_ALREADY_PENDING
  } pool_status_e;

  // Kind code that the block does not name at all.
  localparam logic [2:0] KIND_RESERVED = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [3:0]  task_type;
    logic [31:0] handler;
    logic [31:0] arg;
  } pool_item_t;

  class slot_pool_scoreboard;
    bit          in_use[WSP_SLOTS];
    bit          pending[WSP_SLOTS];
    logic [3:0]  type_of[WSP_SLOTS];
    logic [31:0] handler_of[WSP_SLOTS];
    logic [31:0] arg_of[WSP_SLOTS];
    logic [3:0]  sched_ring[WSP_SLOTS];
    int          ring_head;
    int          ring_tail;
    res_t        expected_results[$];
    int          mismatches;
    int          items_seen;

    function new();
      for (int i = 0; i < WSP_SLOTS; i++) begin
        in_use[i] = 1'b0;
        pending[i] = 1'b0;
        type_of[i] = '0;
        handler_of[i] = '0;
        arg_of[i] = '0;
      end
      ring_head = 0;
      ring_tail = 0;
      mismatches = 0;
      items_seen = 0;
    endfunction

    function int ring_next(int i);
      return (i + 1 >= WSP_SLOTS) ? 0 : i + 1;
    endfunction

    function void queue_result(logic [2:0] st, logic [3:0] s, logic [3:0] ty,
                               logic [31:0] h, logic [31:0] a, logic run, logic last);
      res_t r;
      r.status = st;
      r.slot = s;
      r.rtype = ty;
      r.handler = h;
      r.arg = a;
      r.run = run;
      r.last = last;
      expected_results.push_back(r);
    endfunction

    // Updates the slot pool copy for one accepted item and queues what it must give.
    function void note_item(pool_item_t it);
      int  p;
      bit  found;
      logic [2:0] st;
      items_seen++;
      case (op_e'(it.kind))
        OP_ALLOC: begin
          found = 1'b0;
          for (int i = 0; i < WSP_SLOTS; i++) begin
            if (!found && !in_use[i]) begin
              found = 1'b1;
              in_use[i] = 1'b1;
              pending[i] = 1'b0;
              type_of[i] = it.task_type;
              queue_result(ST_OK, 4'(i), '0, '0, '0, 1'b0, 1'b1);
            end
          end
          if (!found) queue_result(ST_POOL_EXHAUSTED, '0, '0, '0, '0, 1'b0, 1'b1);
        end
        OP_INIT: begin
          handler_of[it.slot] = it.handler;
          arg_of[it.slot] = it.arg;
          pending[it.slot] = 1'b0;
          queue_result(ST_OK, '0, '0, '0, '0, 1'b0, 1'b1);
        end
        OP_SCHED: begin
          if (!in_use[it.slot]) begin
            st = ST_NOT_IN_USE;
          end else if (pending[it.slot]) begin
            st = ST_ALREADY_PENDING;
          end else if (ring_next(ring_tail) == ring_head) begin
            st = ST_RING_FULL;
          end else begin
            pending[it.slot] = 1'b1;
            sched_ring[ring_tail] = it.slot;
            ring_tail = ring_next(ring_tail);
            st = ST_OK;
          end
          queue_result(st, '0, '0, '0, '0, 1'b0, 1'b1);
        end
        OP_KILL: begin
          pending[it.slot] = 1'b0;
          queue_result(ST_OK, '0, '0, '0, '0, 1'b0, 1'b1);
        end
        OP_FREE: begin
          in_use[it.slot] = 1'b0;
          pending[it.slot] = 1'b0;
          queue_result(ST_OK, '0, '0, '0, '0, 1'b0, 1'b1);
        end
        OP_DRAIN: begin
          // Killed and freed slots keep their ring entry; they come out with run low unless scheduled again.
          while (ring_head != ring_tail) begin
            p = int'(sched_ring[ring_head]);
            queue_result(ST_OK, 4'(p), type_of[p], handler_of[p], arg_of[p],
                         pending[p] && (handler_of[p] != '0), 1'b0);
            ring_head = ring_next(ring_head);
            pending[p] = 1'b0;
          end
          queue_result(ST_OK, '0, '0, '0, '0, 1'b0, 1'b1);
        end
        default: begin
          queue_result(ST_OK, '0, '0, '0, '0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d type %0d handler %h arg %h run %0b last %0b",
                   got.status, got.slot, got.rtype, got.handler, got.arg, got.run, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.slot !== want.slot || got.rtype !== want.rtype ||
          got.handler !== want.handler || got.arg !== want.arg || got.run !== want.run ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected status %0d slot %0d type %0d handler %h arg %h run %0b last %0b",
                   want.status, want.slot, want.rtype, want.handler, want.arg, want.run,
                   want.last);
          $display("          actual   status %0d slot %0d type %0d handler %h arg %h run %0b last %0b",
                   got.status, got.slot, got.rtype, got.handler, got.arg, got.run, got.last);
        end
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_work_slot_pool_with_dedup_fifo_unit.sv =====
// Top-level testbench for the work slot pool: stimulus, handshakes and the final verdict.
module tb_work_slot_pool_with_dedup_fifo_unit;
  import wsp_pkg::*;
  import slot_pool_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 300;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 300000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  kind_i = '0;
  logic [3:0]  slot_i = '0;
  logic [3:0]  task_type_i = '0;
  logic [31:0] handler_i = '0;
  logic [31:0] arg_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  out_slot_o;
  logic [3:0]  out_type_o;
  logic [31:0] out_handler_o;
  logic [31:0] out_arg_o;
  logic        run_o;
  logic        last_o;

  slot_pool_scoreboard sb;
  pool_item_t          stimulus[$];
  int                  send_idle_pct = 23;
  int                  recv_idle_pct = 61;
  int                  hold_at = 1 << 30;
  int                  cycle_count = 0;

  work_slot_pool_with_dedup_fifo_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .slot_i       (slot_i),
    .task_type_i  (task_type_i),
    .handler_i    (handler_i),
    .arg_i        (arg_i),
    .empty        (empty),
    .pop          (pop),
    .status_o     (status_o),
    .out_slot_o   (out_slot_o),
    .out_type_o   (out_type_o),
    .out_handler_o(out_handler_o),
    .out_arg_o    (out_arg_o),
    .run_o        (run_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] pick_slot();
    // Alloc hands out the lowest free slots, so low indices are mostly in use.
    if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, 5));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 25) return '1;
    return $urandom;
  endfunction

  task automatic add_item(logic [2:0] kind, logic [3:0] slot, logic [3:0] ty,
                          logic [31:0] h, logic [31:0] a);
    pool_item_t it;
    it.kind = kind;
    it.slot = slot;
    it.task_type = ty;
    it.handler = h;
    it.arg = a;
    stimulus.push_back(it);
  endtask

  task automatic plan_directed();
    add_item(OP_ALLOC, 4'hf, 4'h0, '1, '1);
    add_item(OP_ALLOC, 4'h0, 4'hf, '0, '0);
    add_item(OP_ALLOC, 4'h3, 4'h5, '0, '0);
    add_item(OP_INIT, 4'h0, 4'h0, 32'hffff_ffff, 32'hffff_ffff);
    add_item(OP_INIT, 4'h1, 4'hf, 32'h0, 32'h0);
    // Init does not look at the in-use mark.
    add_item(OP_INIT, 4'hf, 4'ha, 32'h1234_5678, 32'ha5a5_a5a5);
    add_item(OP_SCHED, 4'h0, 4'h0, '0, '0);
    add_item(OP_SCHED, 4'h1, 4'h0, '0, '0);
    add_item(OP_SCHED, 4'h0, 4'h0, '0, '0);
    add_item(OP_SCHED, 4'hf, 4'h0, '0, '0);
    add_item(OP_SCHED, 4'h2, 4'h0, '0, '0);
    add_item(OP_KILL, 4'h2, 4'h0, '0, '0);
    add_item(OP_FREE, 4'h1, 4'h0, '0, '0);
    add_item(OP_DRAIN, 4'h0, 4'h0, '0, '0);
    add_item(OP_DRAIN, 4'hf, 4'hf, '1, '1);
    add_item(OP_NONE, 4'h5, 4'h5, 32'hdead_beef, 32'h0bad_cafe);
    add_item(KIND_RESERVED, 4'hf, 4'hf, '1, '1);
    add_item(OP_KILL, 4'h0, 4'h0, '0, '0);
    add_item(OP_FREE, 4'h0, 4'h0, '0, '0);
    add_item(OP_ALLOC, 4'h0, 4'h9, '0, '0);
  endtask

  task automatic plan_random();
    int roll;
    int first;
    int reps;
    logic [3:0] s;
    first = stimulus.size();
    while (stimulus.size() < first + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        // A job: take a slot, give work to a picked slot and queue it, at times with a kill or drain.
        s = pick_slot();
        add_item(OP_ALLOC, 4'($urandom), 4'($urandom), $urandom, $urandom);
        add_item(OP_INIT, s, 4'($urandom), pick_word(), pick_word());
        add_item(OP_SCHED, s, 4'($urandom), $urandom, $urandom);
        if ($urandom_range(0, 99) < 30) add_item(OP_SCHED, s, 4'($urandom), $urandom, $urandom);
        if ($urandom_range(0, 99) < 20) add_item(OP_KILL, s, 4'($urandom), $urandom, $urandom);
        if ($urandom_range(0, 99) < 25)
          add_item(OP_DRAIN, 4'($urandom), 4'($urandom), $urandom, $urandom);
      end else if (roll < 45) begin
        // Schedule and kill in turn to pile entries into the ring, which may fill it.
        reps = $urandom_range(8, 17);
        repeat (reps) begin
          s = pick_slot();
          add_item(OP_SCHED, s, 4'($urandom), $urandom, $urandom);
          add_item(OP_KILL, s, 4'($urandom), $urandom, $urandom);
        end
        if ($urandom_range(0, 99) < 60)
          add_item(OP_DRAIN, 4'($urandom), 4'($urandom), $urandom, $urandom);
      end else if (roll < 53) begin
        repeat (17) add_item(OP_ALLOC, 4'($urandom), 4'($urandom), $urandom, $urandom);
        repeat (4) add_item(OP_FREE, 4'($urandom), 4'($urandom), $urandom, $urandom);
      end else if (roll < 68) begin
        add_item(OP_DRAIN, 4'($urandom), 4'($urandom), $urandom, $urandom);
      end else if (roll < 80) begin
        add_item($urandom_range(0, 1) ? OP_KILL : OP_FREE, pick_slot(), 4'($urandom),
                 $urandom, $urandom);
      end else begin
        add_item(3'($urandom_range(0, 7)), 4'($urandom), 4'($urandom), pick_word(),
                 pick_word());
      end
    end
  endtask

  task automatic send_all();
    int idx;
    int n;
    idx = 0;
    n = stimulus.size();
    while (idx < n) begin
      @(posedge clk_i);
      if (push && !full) idx++;
      if (idx * 3 < n) begin
        send_idle_pct = 23;
        recv_idle_pct = 61;
      end else if (idx * 3 < 2 * n) begin
        send_idle_pct = 61;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (idx < n && $urandom_range(0, 99) >= send_idle_pct) begin
        push        <= 1'b1;
        kind_i      <= stimulus[idx].kind;
        slot_i      <= stimulus[idx].slot;
        task_type_i <= stimulus[idx].task_type;
        handler_i   <= stimulus[idx].handler;
        arg_i       <= stimulus[idx].arg;
      end else begin
        push <= 1'b0;
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off so that the block backs up.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && sb.items_seen >= hold_at) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full)
        sb.note_item('{kind_i, slot_i, task_type_i, handler_i, arg_i});
      if (pop && !empty)
        sb.check_result(res_t'({status_o, out_slot_o, out_type_o, out_handler_o, out_arg_o,
                                run_o, last_o}));
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    sb = new();
    plan_directed();
    plan_random();
    hold_at = stimulus.size() * 2 / 3 + 8;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_all();
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== work_slot_pool_with_dedup_fifo_unit.f =====
rtl/core/wsp_pkg.sv
rtl/core/wsp_fifo.sv
rtl/core/wsp_front.sv
rtl/core/wsp_back.sv
rtl/core/work_slot_pool_with_dedup_fifo_unit.sv
bench/slot_pool_check_pkg.sv
bench/tb_work_slot_pool_with_dedup_fifo_unit.sv
